### sv/stereo_feedback_comb_reverb_core_macros.svh
// Assertion macros shared by the reverb core checker.
`ifndef STEREO_FEEDBACK_COMB_REVERB_CORE_MACROS_SVH
`define STEREO_FEEDBACK_COMB_REVERB_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define SFCR_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfcr same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define SFCR_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfcr next-cycle check failed");

`endif

### sv/sfcr_pkg.sv
// Constants shared by the stereo feedback comb reverb core and its checker.
package sfcr_pkg;

    // Default sizes
    localparam int LEFT_DELAY_DEF   = 719;
    localparam int RIGHT_DELAY_DEF  = 1061;
    localparam int SAMPLE_WIDTH_DEF = 16;

    // Feedback gains, Q0.16
    localparam int GAIN_LEFT  = 36045;
    localparam int GAIN_RIGHT = 32768;

    // Mix register, Q1.16
    localparam int MIX_W    = 17;
    localparam int MIX_FULL = 65536;

    // Half LSB of a Q16 product, for round to nearest
    localparam int ROUND_HALF = 32768;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] REG_MIX_ADDR = 3'd0;

endpackage

### sv/stereo_feedback_comb_reverb_core.sv
// A stereo frame is taken only in the idle state, once the previous frame is
// done; the single shared multiplier forms six products per frame (gain, dry
// and wet terms for each channel).
// The input is taken while an earlier output word still waits.
// Reset (rst_n, async, active low): mix, positions and control clear; each
// delay line reads as zero until its write pointer first wraps.
module stereo_feedback_comb_reverb_core #(
    parameter int LEFT_DELAY   = sfcr_pkg::LEFT_DELAY_DEF,
    parameter int RIGHT_DELAY  = sfcr_pkg::RIGHT_DELAY_DEF,
    parameter int SAMPLE_WIDTH = sfcr_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // input stream
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // left_in, right_in
    input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
    // output stream
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // left_out, right_out
    output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]     m_axis_tdata,
    // configuration port
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [sfcr_pkg::APB_ADDR_W-1:0]         paddr,
    input  logic [sfcr_pkg::APB_DATA_W-1:0]         pwdata,
    output logic [sfcr_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                    pready
);
    import sfcr_pkg::*;

    localparam int SW      = SAMPLE_WIDTH;
    localparam int TDATA_W = ((2*SW+7)/8)*8;
    localparam int LAW     = (LEFT_DELAY > 1) ? $clog2(LEFT_DELAY) : 1;
    localparam int RAW     = (RIGHT_DELAY > 1) ? $clog2(RIGHT_DELAY) : 1;
    localparam int PW      = SW + 18;
    localparam int BW      = 18;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WET_L,
        S_DRY_L,
        S_MIX_L,
        S_SUM_L,
        S_DRY_R,
        S_MIX_R,
        S_SUM_R,
        S_HOLD
    } state_t;

    state_t                 state_reg, state_next;
    logic [LAW-1:0]         lpos_reg, lpos_next;
    logic [RAW-1:0]         rpos_reg, rpos_next;
    logic                   lfull_reg, lfull_next;
    logic                   rfull_reg, rfull_next;
    logic [MIX_W-1:0]       mix_reg, mix_next;
    logic signed [SW-1:0]   dl_reg, dl_next;
    logic signed [SW-1:0]   dr_reg, dr_next;
    logic signed [SW-1:0]   wet_reg, wet_next;
    logic signed [PW-1:0]   prod_reg, prod_next;
    logic signed [PW-1:0]   acc_reg, acc_next;
    logic signed [SW-1:0]   yl_reg, yl_next;
    logic signed [SW-1:0]   yr_reg, yr_next;
    logic                   out_valid_reg, out_valid_next;
    logic signed [SW-1:0]   out_l_reg, out_l_next;
    logic signed [SW-1:0]   out_r_reg, out_r_next;

    // delay line memories and their registered read data
    logic [SW-1:0]          left_mem [LEFT_DELAY];
    logic [SW-1:0]          right_mem [RIGHT_DELAY];
    logic signed [SW-1:0]   rdl_reg;
    logic signed [SW-1:0]   rdr_reg;

    logic                   in_fire;
    logic                   cfg_wr;
    logic                   wr_left;
    logic                   wr_right;
    logic                   out_free;
    logic                   mix_over;
    logic [MIX_W-1:0]       mix_eff;
    logic [MIX_W-1:0]       mix_inv;
    logic signed [SW-1:0]   mul_a;
    logic signed [BW-1:0]   mul_b;
    logic signed [PW-1:0]   prod_rnd;
    logic signed [PW:0]     sum_full;
    logic signed [SW+2:0]   sum_q;
    logic signed [SW-1:0]   sum_sat;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign out_free = !out_valid_reg || m_axis_tready;

    // Ports
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = TDATA_W'({out_r_reg, out_l_reg});
    assign pready        = 1'b1;
    assign prdata        = (paddr == REG_MIX_ADDR) ? APB_DATA_W'(mix_reg) : '0;

    // Clamp mix to full scale and form its complement
    assign mix_over = mix_reg[MIX_W-1] && (|mix_reg[MIX_W-2:0]);
    assign mix_eff  = mix_over ? MIX_W'(MIX_FULL) : mix_reg;
    assign mix_inv  = MIX_W'(MIX_FULL) - mix_eff;

    // Round the registered product to Q16 for the wet term
    assign prod_rnd = prod_reg + PW'(ROUND_HALF);

    // Add dry and wet products, round, saturate
    assign sum_full = {acc_reg[PW-1], acc_reg} + {prod_reg[PW-1], prod_reg}
                      + (PW+1)'(ROUND_HALF);
    assign sum_q    = sum_full[PW:16];
    always_comb
    begin
        if ((&sum_q[SW+2:SW-1]) || !(|sum_q[SW+2:SW-1]))
        begin
            sum_sat = sum_q[SW-1:0];
        end
        else
        begin
            sum_sat = {sum_q[SW+2], {(SW-1){~sum_q[SW+2]}}};
        end
    end

    // Select operands of the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_WET_L:
            begin
                mul_a = lfull_reg ? rdl_reg : '0;
                mul_b = BW'(GAIN_LEFT);
            end
            S_DRY_L:
            begin
                mul_a = dl_reg;
                mul_b = signed'({1'b0, mix_inv});
            end
            S_MIX_L:
            begin
                mul_a = wet_reg;
                mul_b = signed'({1'b0, mix_eff});
            end
            S_SUM_L:
            begin
                mul_a = rfull_reg ? rdr_reg : '0;
                mul_b = BW'(GAIN_RIGHT);
            end
            S_DRY_R:
            begin
                mul_a = dr_reg;
                mul_b = signed'({1'b0, mix_inv});
            end
            S_MIX_R:
            begin
                mul_a = wet_reg;
                mul_b = signed'({1'b0, mix_eff});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        lpos_next      = lpos_reg;
        rpos_next      = rpos_reg;
        lfull_next     = lfull_reg;
        rfull_next     = rfull_reg;
        mix_next       = mix_reg;
        dl_next        = dl_reg;
        dr_next        = dr_reg;
        wet_next       = wet_reg;
        prod_next      = mul_a * mul_b;
        acc_next       = acc_reg;
        yl_next        = yl_reg;
        yr_next        = yr_reg;
        out_valid_next = out_valid_reg;
        out_l_next     = out_l_reg;
        out_r_next     = out_r_reg;
        wr_left        = 1'b0;
        wr_right       = 1'b0;

        if (cfg_wr && (paddr == REG_MIX_ADDR))
        begin
            mix_next = pwdata[MIX_W-1:0];
        end

        // drop the output word once taken
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    dl_next    = s_axis_tdata[SW-1:0];
                    dr_next    = s_axis_tdata[2*SW-1:SW];
                    state_next = S_WET_L;
                end
            end
            S_WET_L:
            begin
                state_next = S_DRY_L;
            end
            S_DRY_L:
            begin
                wet_next   = prod_rnd[SW+15:16];
                state_next = S_MIX_L;
            end
            S_MIX_L:
            begin
                acc_next   = prod_reg;
                state_next = S_SUM_L;
            end
            S_SUM_L:
            begin
                yl_next = sum_sat;
                wr_left = 1'b1;
                if (lpos_reg == LAW'(LEFT_DELAY - 1))
                begin
                    lpos_next  = '0;
                    lfull_next = 1'b1;
                end
                else
                begin
                    lpos_next = lpos_reg + 1'b1;
                end
                state_next = S_DRY_R;
            end
            S_DRY_R:
            begin
                wet_next   = prod_rnd[SW+15:16];
                state_next = S_MIX_R;
            end
            S_MIX_R:
            begin
                acc_next   = prod_reg;
                state_next = S_SUM_R;
            end
            S_SUM_R:
            begin
                yr_next  = sum_sat;
                wr_right = 1'b1;
                if (rpos_reg == RAW'(RIGHT_DELAY - 1))
                begin
                    rpos_next  = '0;
                    rfull_next = 1'b1;
                end
                else
                begin
                    rpos_next = rpos_reg + 1'b1;
                end
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_l_next     = yl_reg;
                    out_r_next     = sum_sat;
                    state_next     = S_IDLE;
                end
                else
                begin
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_l_next     = yl_reg;
                    out_r_next     = yr_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lpos_reg      <= '0;
            rpos_reg      <= '0;
            lfull_reg     <= 1'b0;
            rfull_reg     <= 1'b0;
            mix_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lpos_reg      <= lpos_next;
            rpos_reg      <= rpos_next;
            lfull_reg     <= lfull_next;
            rfull_reg     <= rfull_next;
            mix_reg       <= mix_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Advance datapath registers
    always_ff @(posedge clk)
    begin
        dl_reg    <= dl_next;
        dr_reg    <= dr_next;
        wet_reg   <= wet_next;
        prod_reg  <= prod_next;
        acc_reg   <= acc_next;
        yl_reg    <= yl_next;
        yr_reg    <= yr_next;
        out_l_reg <= out_l_next;
        out_r_reg <= out_r_next;
    end

    // Store each channel's output into its delay line
    always_ff @(posedge clk)
    begin
        if (wr_left)
        begin
            left_mem[lpos_reg] <= sum_sat;
        end
        if (wr_right)
        begin
            right_mem[rpos_reg] <= sum_sat;
        end
    end

    // Read the delayed words when a frame is taken
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            rdl_reg <= left_mem[lpos_reg];
            rdr_reg <= right_mem[rpos_reg];
        end
    end

endmodule

### sv/sfcr_checker.sv
// Port-level checker for the reverb core, bound into the core module.
`include "stereo_feedback_comb_reverb_core_macros.svh"

module sfcr_checker #(
    parameter int SAMPLE_WIDTH = sfcr_pkg::SAMPLE_WIDTH_DEF
) (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 s_axis_tvalid,
    input logic                                 s_axis_tready,
    input logic                                 m_axis_tvalid,
    input logic                                 m_axis_tready,
    input logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]  m_axis_tdata,
    input logic                                 psel,
    input logic                                 penable,
    input logic                                 pwrite,
    input logic [sfcr_pkg::APB_ADDR_W-1:0]      paddr,
    input logic [sfcr_pkg::APB_DATA_W-1:0]      pwdata,
    input logic [sfcr_pkg::APB_DATA_W-1:0]      prdata
);
    import sfcr_pkg::*;

    // a taken frame keeps the core busy on the next cycle
    `SFCR_ASSERT_NXT(a_busy_after_take, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // no result appears the cycle right after a frame is taken
    `SFCR_ASSERT_NXT(a_no_instant_result, s_axis_tvalid && s_axis_tready && !m_axis_tvalid, !m_axis_tvalid)

    // a stalled output word holds
    `SFCR_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // the mix register reads back what was written
    `SFCR_ASSERT_NXT(a_mix_readback, psel && penable && pwrite && (paddr == REG_MIX_ADDR), (paddr != REG_MIX_ADDR) || (prdata == APB_DATA_W'($past(pwdata[MIX_W-1:0]))))

endmodule

bind stereo_feedback_comb_reverb_core sfcr_checker #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_sfcr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata)
);
